FILE: src/qci_pkg.sv
// shared constants, codes and control types of the quadruple code interpreter
package qci_pkg;

  localparam int VALUE_DEPTH_DEF = 1024;
  localparam int STACK_DEPTH_DEF = 16;

  localparam int LINE_W     = 13;
  localparam int START_W    = 12;
  localparam int WORD_W     = 32;
  localparam int ARG1_W     = 14;
  localparam int ARG_W      = 13;
  localparam int OP_W       = 5;
  localparam int SIDX_W     = 11;
  localparam int FAULT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_OUT   = 5'd0;
  localparam logic [OP_W-1:0] OP_IN    = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd3;
  localparam logic [OP_W-1:0] OP_COPY  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 5'd5;
  localparam logic [OP_W-1:0] OP_MOD   = 5'd6;
  localparam logic [OP_W-1:0] OP_GT    = 5'd7;
  localparam logic [OP_W-1:0] OP_LT    = 5'd8;
  localparam logic [OP_W-1:0] OP_LE    = 5'd9;
  localparam logic [OP_W-1:0] OP_GE    = 5'd10;
  localparam logic [OP_W-1:0] OP_EQ    = 5'd11;
  localparam logic [OP_W-1:0] OP_NE    = 5'd12;
  localparam logic [OP_W-1:0] OP_PARAM = 5'd13;
  localparam logic [OP_W-1:0] OP_GOTO  = 5'd14;
  localparam logic [OP_W-1:0] OP_CALL  = 5'd15;
  localparam logic [OP_W-1:0] OP_RET   = 5'd16;

  localparam logic ACT_LOAD = 1'b0;

  localparam logic [ARG1_W-1:0] ARG_VALUE_OUT = '1;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_DIV0  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_STACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 2'd1;

  typedef enum logic [1:0] {
    RD_X,
    RD_Y,
    RD_P
  } rd_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    clr_we;
    rd_sel_t rd_sel;
    logic    lat_x;
    logic    lat_y;
    logic    lat_p;
    logic    div_start;
    logic    exec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic clear_last;
    logic skip_reads;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: src/qci_if.sv
// valid/ready channel interfaces: instruction input, result output, configuration write
interface qci_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [qci_pkg::OP_W-1:0]             opcode;
  logic signed [qci_pkg::ARG1_W-1:0]    arg_one;
  logic [qci_pkg::ARG_W-1:0]            arg_two;
  logic [qci_pkg::ARG_W-1:0]            arg_three;
  logic signed [qci_pkg::WORD_W-1:0]    data_word;
  modport source (output valid, action, opcode, arg_one, arg_two, arg_three, data_word,
                  input ready);
  modport sink (input valid, action, opcode, arg_one, arg_two, arg_three, data_word,
                output ready);
endinterface

interface qci_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [qci_pkg::LINE_W-1:0]           next_line;
  logic                                 print_valid;
  logic                                 print_is_string;
  logic signed [qci_pkg::WORD_W-1:0]    print_data;
  logic                                 halted;
  logic [qci_pkg::FAULT_W-1:0]          fault;
  modport source (output valid, next_line, print_valid, print_is_string, print_data,
                  halted, fault, input ready);
  modport sink (input valid, next_line, print_valid, print_is_string, print_data,
                halted, fault, output ready);
endinterface

interface qci_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [qci_pkg::CFG_IDX_W-1:0]        index;
  logic [qci_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/qci_ram.sv
// generic single write port ram with registered read
module qci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/qci_divider.sv
// iterative unsigned restoring divider, one quotient bit per cycle
module qci_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qci_pkg::WORD_W-1:0] dividend,
  input  logic [qci_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [qci_pkg::WORD_W-1:0] quot,
  output logic [qci_pkg::WORD_W-1:0] rem
);

  localparam int W  = qci_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  always_comb begin
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r[W-1:0];

endmodule

FILE: src/qci_datapath.sv
// interpreter datapath: value store, index stack, line counter, divider and result register
module qci_datapath #(
  parameter int VALUE_DEPTH = qci_pkg::VALUE_DEPTH_DEF,
  parameter int STACK_DEPTH = qci_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  qci_pkg::cmd_t   cmd,
  output qci_pkg::sts_t   sts,
  qci_in_if.sink          in_ch,
  qci_out_if.source       out_ch,
  qci_cfg_if.sink         cfg_ch
);

  localparam int AW = $clog2(VALUE_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W  = qci_pkg::WORD_W;
  localparam int LW = qci_pkg::LINE_W;

  function automatic logic [AW-1:0] vidx(input logic [qci_pkg::ARG1_W-1:0] raw);
    return raw[AW-1:0];
  endfunction

  // configuration
  logic [qci_pkg::START_W-1:0] start_r;
  logic [LW-1:0]               len_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        qci_pkg::CFG_START_LINE: start_r <= cfg_ch.data[qci_pkg::START_W-1:0];
        qci_pkg::CFG_PROG_LEN:   len_r   <= cfg_ch.data[LW-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic                          act_r;
  logic [qci_pkg::OP_W-1:0]      op_r;
  logic [qci_pkg::ARG1_W-1:0]    a1_r;
  logic [qci_pkg::ARG_W-1:0]     a2_r;
  logic [qci_pkg::ARG_W-1:0]     a3_r;
  logic [W-1:0]                  word_r;

  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      act_r  <= in_ch.action;
      op_r   <= in_ch.opcode;
      a1_r   <= in_ch.arg_one;
      a2_r   <= in_ch.arg_two;
      a3_r   <= in_ch.arg_three;
      word_r <= in_ch.data_word;
    end
  end

  // architectural state
  logic [LW-1:0]               line_r, line_nxt;
  logic                        stopped_r, stopped_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [qci_pkg::SIDX_W-1:0]  stack_r [STACK_DEPTH];
  logic [CW-1:0]               count_m1;
  logic [qci_pkg::SIDX_W-1:0]  stack_top;
  logic                        stack_full;

  assign count_m1   = count_r - CW'(1);
  assign stack_top  = stack_r[count_m1[SW-1:0]];
  assign stack_full = count_r >= CW'(STACK_DEPTH);

  // value store
  logic [AW-1:0] clr_cnt_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;
  logic          we_e;
  logic [AW-1:0] waddr_e;
  logic [W-1:0]  wdata_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      qci_pkg::RD_X: ram_raddr = vidx({1'b0, a2_r});
      qci_pkg::RD_Y: ram_raddr = vidx({1'b0, a3_r});
      qci_pkg::RD_P: ram_raddr = vidx(a1_r);
      default:       ram_raddr = vidx({1'b0, a2_r});
    endcase
  end

  assign ram_we    = cmd.clr_we || (cmd.exec && we_e);
  assign ram_waddr = cmd.clr_we ? clr_cnt_r : waddr_e;
  assign ram_wdata = cmd.clr_we ? '0 : wdata_e;

  qci_ram #(
    .WIDTH (W),
    .DEPTH (VALUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [W-1:0] x_r, y_r, p_r;

  always_ff @(posedge clk) begin
    if (cmd.lat_x) begin
      x_r <= ram_rdata;
    end
    if (cmd.lat_y) begin
      y_r <= ram_rdata;
    end
    if (cmd.lat_p) begin
      p_r <= ram_rdata;
    end
  end

  // signed divide and modulo on magnitudes
  logic         nx, ny;
  logic [W-1:0] mx, my, dq, dr, div_res;
  logic         div_done;

  assign nx = x_r[W-1];
  assign ny = y_r[W-1];
  assign mx = nx ? -x_r : x_r;
  assign my = ny ? -y_r : y_r;

  qci_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mx),
    .divisor  (my),
    .done     (div_done),
    .quot     (dq),
    .rem      (dr)
  );

  assign div_res = (op_r == qci_pkg::OP_DIV) ? ((nx != ny) ? -dq : dq)
                                             : (nx ? -dr : dr);

  // instruction execution
  logic                        halted_now;
  logic                        is_div;
  logic                        take;
  logic [LW-1:0]               nl;
  logic                        push_en;
  logic [qci_pkg::SIDX_W-1:0]  push_val;
  logic                        pv, ps;
  logic [W-1:0]                pd;
  logic [qci_pkg::FAULT_W-1:0] fault;

  assign halted_now = stopped_r || (line_r >= len_r);
  assign is_div     = (op_r == qci_pkg::OP_DIV) || (op_r == qci_pkg::OP_MOD);

  always_comb begin
    line_nxt    = line_r;
    stopped_nxt = stopped_r;
    count_nxt   = count_r;
    push_en     = 1'b0;
    push_val    = '0;
    we_e        = 1'b0;
    waddr_e     = vidx(a1_r);
    wdata_e     = '0;
    pv          = 1'b0;
    ps          = 1'b0;
    pd          = '0;
    fault       = qci_pkg::FAULT_NONE;
    take        = 1'b0;
    nl          = line_r + LW'(1);
    if (act_r == qci_pkg::ACT_LOAD) begin
      we_e        = 1'b1;
      waddr_e     = vidx({1'b0, a2_r});
      wdata_e     = word_r;
      line_nxt    = {1'b0, start_r};
      count_nxt   = '0;
      stopped_nxt = {1'b0, start_r} >= len_r;
    end else if (halted_now) begin
      stopped_nxt = 1'b1;
    end else begin
      case (op_r)
        qci_pkg::OP_OUT: begin
          pv = 1'b1;
          if (a1_r == qci_pkg::ARG_VALUE_OUT) begin
            pd = x_r;
          end else begin
            ps = 1'b1;
            pd = W'($signed(a1_r));
          end
        end
        qci_pkg::OP_IN: begin
          we_e    = 1'b1;
          wdata_e = word_r;
        end
        qci_pkg::OP_ADD: begin
          we_e    = 1'b1;
          wdata_e = x_r + y_r;
        end
        qci_pkg::OP_SUB: begin
          we_e    = 1'b1;
          wdata_e = x_r - y_r;
        end
        qci_pkg::OP_COPY: begin
          we_e    = 1'b1;
          wdata_e = x_r;
        end
        qci_pkg::OP_DIV, qci_pkg::OP_MOD: begin
          if (y_r == '0) begin
            fault = qci_pkg::FAULT_DIV0;
          end else begin
            we_e    = 1'b1;
            wdata_e = div_res;
          end
        end
        qci_pkg::OP_GT: take = $signed(p_r) > $signed(x_r);
        qci_pkg::OP_LT: take = $signed(p_r) < $signed(x_r);
        qci_pkg::OP_LE: take = $signed(p_r) <= $signed(x_r);
        qci_pkg::OP_GE: take = $signed(p_r) >= $signed(x_r);
        qci_pkg::OP_EQ: take = p_r == x_r;
        qci_pkg::OP_NE: take = p_r != x_r;
        qci_pkg::OP_PARAM: begin
          if (stack_full) begin
            fault = qci_pkg::FAULT_STACK;
          end else begin
            push_en  = 1'b1;
            push_val = a1_r[qci_pkg::SIDX_W-1:0];
          end
        end
        qci_pkg::OP_GOTO: begin
          nl = ($signed(a1_r) <= 0) ? '0 : (a1_r[LW-1:0] - LW'(1));
        end
        qci_pkg::OP_CALL: begin
          if (stack_full) begin
            fault = qci_pkg::FAULT_STACK;
          end else begin
            push_en  = 1'b1;
            push_val = a3_r[qci_pkg::SIDX_W-1:0];
          end
        end
        qci_pkg::OP_RET: begin
          if (count_r != '0) begin
            count_nxt = count_m1;
            we_e      = 1'b1;
            waddr_e   = vidx({3'b0, stack_top});
            wdata_e   = W'($signed(a1_r));
          end
          nl          = line_r;
          stopped_nxt = 1'b1;
        end
        default: ;
      endcase
      if (take) begin
        nl = (a3_r == '0) ? '0 : (a3_r - LW'(1));
      end
      if (push_en) begin
        count_nxt = count_r + CW'(1);
      end
      line_nxt = nl;
      if (nl >= len_r) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r    <= '0;
      stopped_r <= 1'b0;
      count_r   <= '0;
    end else if (cmd.exec) begin
      line_r    <= line_nxt;
      stopped_r <= stopped_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_en) begin
      stack_r[count_r[SW-1:0]] <= push_val;
    end
  end

  // result and output register
  logic [LW-1:0]               res_line_r;
  logic                        res_pv_r, res_ps_r, res_halt_r;
  logic [W-1:0]                res_pd_r;
  logic [qci_pkg::FAULT_W-1:0] res_fault_r;
  logic                        out_valid_r;
  logic [LW-1:0]               out_line_r;
  logic                        out_pv_r, out_ps_r, out_halt_r;
  logic [W-1:0]                out_pd_r;
  logic [qci_pkg::FAULT_W-1:0] out_fault_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_line_r  <= line_nxt;
      res_pv_r    <= pv;
      res_ps_r    <= ps;
      res_pd_r    <= pd;
      res_halt_r  <= stopped_nxt;
      res_fault_r <= fault;
    end
    if (cmd.out_load) begin
      out_line_r  <= res_line_r;
      out_pv_r    <= res_pv_r;
      out_ps_r    <= res_ps_r;
      out_pd_r    <= res_pd_r;
      out_halt_r  <= res_halt_r;
      out_fault_r <= res_fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.next_line       = out_line_r;
  assign out_ch.print_valid     = out_pv_r;
  assign out_ch.print_is_string = out_ps_r;
  assign out_ch.print_data      = out_pd_r;
  assign out_ch.halted          = out_halt_r;
  assign out_ch.fault           = out_fault_r;

  // status
  assign sts.in_valid   = in_ch.valid;
  assign sts.clear_last = clr_cnt_r == AW'(VALUE_DEPTH - 1);
  assign sts.skip_reads = (act_r == qci_pkg::ACT_LOAD) || halted_now;
  assign sts.need_div   = (act_r != qci_pkg::ACT_LOAD) && !halted_now && is_div &&
                          (y_r != '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || out_ch.ready;

endmodule

FILE: src/qci_controller.sv
// interpreter sequencer: store clearing, operand reads, divide wait, result handoff
module qci_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  qci_pkg::sts_t sts,
  output qci_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RDX   = 9'b000000100,
    ST_RDY   = 9'b000001000,
    ST_RDP   = 9'b000010000,
    ST_WAITP = 9'b000100000,
    ST_EXEC  = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = qci_pkg::RD_X;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = ST_RDX;
        end
      end
      ST_RDX: begin
        cmd.rd_sel = qci_pkg::RD_X;
        state_nxt  = sts.skip_reads ? ST_EXEC : ST_RDY;
      end
      ST_RDY: begin
        cmd.rd_sel = qci_pkg::RD_Y;
        cmd.lat_x  = 1'b1;
        state_nxt  = ST_RDP;
      end
      ST_RDP: begin
        cmd.rd_sel = qci_pkg::RD_P;
        cmd.lat_y  = 1'b1;
        state_nxt  = ST_WAITP;
      end
      ST_WAITP: begin
        cmd.rd_sel = qci_pkg::RD_P;
        cmd.lat_p  = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/quad_code_interpreter.sv
// top level of the quadruple code interpreter
//
//   channel   direction  payload
//   in_ch     in         action, opcode, arg_one, arg_two, arg_three, data_word
//   out_ch    out        next_line, print_valid, print_is_string, print_data, halted, fault
//   cfg_ch    in         index, data (0 start_line, 1 program_length)
//
// an item passes from transfer in to the result register through three value store reads
// on the single read port (x, y, then p) plus execute and handoff; load and halted items
// skip the reads, and divide and modulo with a nonzero divisor wait for the bit-serial divider
// after reset every value store word is cleared to zero with in_ch.ready low
// a result waiting on out_ch holds the next item in its final step until transferred
module quad_code_interpreter #(
  parameter int VALUE_DEPTH = qci_pkg::VALUE_DEPTH_DEF,
  parameter int STACK_DEPTH = qci_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qci_in_if.sink     in_ch,
  qci_out_if.source  out_ch,
  qci_cfg_if.sink    cfg_ch
);

  qci_pkg::cmd_t cmd;
  qci_pkg::sts_t sts;

  qci_controller u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  qci_datapath #(
    .VALUE_DEPTH (VALUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

FILE: verif/tb_quad_code_interpreter.sv
// self-checking testbench for quad_code_interpreter: predicted results vs dut output
`timescale 1ns / 100ps
module tb_quad_code_interpreter;

  typedef struct packed {
    logic                              action;
    logic [qci_pkg::OP_W-1:0]          opcode;
    logic signed [qci_pkg::ARG1_W-1:0] arg_one;
    logic [qci_pkg::ARG_W-1:0]         arg_two;
    logic [qci_pkg::ARG_W-1:0]         arg_three;
    logic signed [qci_pkg::WORD_W-1:0] data_word;
  } instr_t;

  typedef struct packed {
    logic [qci_pkg::LINE_W-1:0]  next_line;
    logic                        print_valid;
    logic                        print_is_string;
    logic [qci_pkg::WORD_W-1:0]  print_data;
    logic                        halted;
    logic [qci_pkg::FAULT_W-1:0] fault;
  } outcome_t;

  localparam int VDEPTH = qci_pkg::VALUE_DEPTH_DEF;
  localparam int SDEPTH = qci_pkg::STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  qci_in_if  in_ch ();
  qci_out_if out_ch ();
  qci_cfg_if cfg_ch ();

  quad_code_interpreter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [qci_pkg::WORD_W-1:0]  vals [VDEPTH];
  logic [qci_pkg::SIDX_W-1:0]  idx_stack [SDEPTH];
  int unsigned                 depth_used;
  logic [qci_pkg::LINE_W-1:0]  pc;
  logic                        stopped;
  logic [qci_pkg::START_W-1:0] main_line;
  logic [qci_pkg::LINE_W-1:0]  prog_len;

  instr_t   pending_instrs [$];
  outcome_t expected_outcomes [$];
  int       errors;
  int       cycles;
  bit       no_idle;
  int       hold_cycles;

  function automatic logic [qci_pkg::LINE_W-1:0] jump_line(int signed one_based);
    if (one_based <= 0) return '0;
    return qci_pkg::LINE_W'(one_based - 1);
  endfunction

  function automatic bit push_idx(logic [qci_pkg::SIDX_W-1:0] v);
    if (depth_used >= SDEPTH) return 1'b0;
    idx_stack[depth_used] = v;
    depth_used++;
    return 1'b1;
  endfunction

  function automatic void add_instr(instr_t it);
    pending_instrs.insert(pending_instrs.size(), it);
  endfunction

  function automatic outcome_t execute_instr(instr_t it);
    outcome_t o;
    logic [qci_pkg::WORD_W-1:0] x, y, p, mx, my, r;
    logic [qci_pkg::LINE_W-1:0] nxt;
    bit take;
    o = '0;
    take = 0;
    if (it.action == qci_pkg::ACT_LOAD) begin
      vals[it.arg_two % VDEPTH] = it.data_word;
      pc = qci_pkg::LINE_W'(main_line);
      depth_used = 0;
      stopped = (pc >= prog_len);
    end else if (!stopped && pc < prog_len) begin
      nxt = pc + 1'b1;
      x = vals[it.arg_two % VDEPTH];
      y = vals[it.arg_three % VDEPTH];
      p = vals[$unsigned(it.arg_one) % VDEPTH];
      case (it.opcode)
        qci_pkg::OP_OUT: begin
          o.print_valid = 1'b1;
          if (it.arg_one == qci_pkg::ARG_VALUE_OUT) o.print_data = x;
          else begin
            o.print_is_string = 1'b1;
            o.print_data = qci_pkg::WORD_W'(it.arg_one);
          end
        end
        qci_pkg::OP_IN: vals[$unsigned(it.arg_one) % VDEPTH] = it.data_word;
        qci_pkg::OP_ADD: vals[$unsigned(it.arg_one) % VDEPTH] = x + y;
        qci_pkg::OP_SUB: vals[$unsigned(it.arg_one) % VDEPTH] = x - y;
        qci_pkg::OP_COPY: vals[$unsigned(it.arg_one) % VDEPTH] = x;
        qci_pkg::OP_DIV, qci_pkg::OP_MOD: begin
          if (y == 0) o.fault = qci_pkg::FAULT_DIV0;
          else begin
            mx = x[31] ? -x : x;
            my = y[31] ? -y : y;
            if (it.opcode == qci_pkg::OP_DIV) begin
              r = mx / my;
              if (x[31] != y[31]) r = -r;
            end else begin
              r = mx % my;
              if (x[31]) r = -r;
            end
            vals[$unsigned(it.arg_one) % VDEPTH] = r;
          end
        end
        qci_pkg::OP_GT: take = $signed(p) > $signed(x);
        qci_pkg::OP_LT: take = $signed(p) < $signed(x);
        qci_pkg::OP_LE: take = $signed(p) <= $signed(x);
        qci_pkg::OP_GE: take = $signed(p) >= $signed(x);
        qci_pkg::OP_EQ: take = p == x;
        qci_pkg::OP_NE: take = p != x;
        qci_pkg::OP_PARAM:
          if (!push_idx(qci_pkg::SIDX_W'($unsigned(it.arg_one)))) o.fault = qci_pkg::FAULT_STACK;
        qci_pkg::OP_GOTO: nxt = jump_line(int'(it.arg_one));
        qci_pkg::OP_CALL:
          if (!push_idx(qci_pkg::SIDX_W'(it.arg_three))) o.fault = qci_pkg::FAULT_STACK;
        qci_pkg::OP_RET: begin
          if (depth_used > 0) begin
            depth_used--;
            vals[idx_stack[depth_used] % VDEPTH] = qci_pkg::WORD_W'(it.arg_one);
          end
          nxt = pc;
          stopped = 1'b1;
        end
        default: ;
      endcase
      if (take) nxt = jump_line(int'({1'b0, it.arg_three}));
      pc = nxt;
      if (pc >= prog_len) stopped = 1'b1;
    end else begin
      stopped = 1'b1;
    end
    o.next_line = pc;
    o.halted = stopped || pc >= prog_len;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_instrs.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
        instr_t it;
        it = pending_instrs.pop_front();
        expected_outcomes.insert(expected_outcomes.size(), execute_instr(it));
        in_ch.valid <= 1'b1;
        in_ch.action <= it.action;
        in_ch.opcode <= it.opcode;
        in_ch.arg_one <= it.arg_one;
        in_ch.arg_two <= it.arg_two;
        in_ch.arg_three <= it.arg_three;
        in_ch.data_word <= it.data_word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rst_n ? 1'b0 : (no_idle || $urandom_range(99) >= 6);
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(out_ch.next_line), 64'(0));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_ch.next_line !== want.next_line)
          report_mismatch("next_line", 64'(out_ch.next_line), 64'(want.next_line));
        if (out_ch.print_valid !== want.print_valid)
          report_mismatch("print_valid", 64'(out_ch.print_valid), 64'(want.print_valid));
        if (out_ch.print_is_string !== want.print_is_string)
          report_mismatch("print_is_string", 64'(out_ch.print_is_string),
                          64'(want.print_is_string));
        if (out_ch.print_data !== want.print_data)
          report_mismatch("print_data", 64'(out_ch.print_data), 64'(want.print_data));
        if (out_ch.halted !== want.halted)
          report_mismatch("halted", 64'(out_ch.halted), 64'(want.halted));
        if (out_ch.fault !== want.fault)
          report_mismatch("fault", 64'(out_ch.fault), 64'(want.fault));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [qci_pkg::CFG_IDX_W-1:0] idx,
                           logic [qci_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == qci_pkg::CFG_START_LINE) main_line = qci_pkg::START_W'(val);
    else prog_len = qci_pkg::LINE_W'(val);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() > 0 || expected_outcomes.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic instr_t mk(logic act, logic [qci_pkg::OP_W-1:0] op, int a1, int a2,
                                int a3, int w);
    instr_t it;
    it.action = act;
    it.opcode = op;
    it.arg_one = qci_pkg::ARG1_W'(a1);
    it.arg_two = qci_pkg::ARG_W'(a2);
    it.arg_three = qci_pkg::ARG_W'(a3);
    it.data_word = w;
    return it;
  endfunction

  // a load then a random program, mostly of small indices so values interact
  task automatic queue_program(int n);
    instr_t it;
    int k;
    logic [95:0] raw;
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, $urandom_range(15), 0, $urandom));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 5) begin
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(instr_t)-1:0];
      end else begin
        it = mk(1'b1, qci_pkg::OP_W'($urandom_range(k < 8 ? 31 : 16)), $urandom_range(15),
                $urandom_range(15), $urandom_range(15), $urandom);
        if ($urandom_range(9) == 0) it.arg_one = qci_pkg::ARG1_W'($urandom);
        if ($urandom_range(9) == 0) it.arg_two = qci_pkg::ARG_W'($urandom);
        if ($urandom_range(9) == 0) it.arg_three = qci_pkg::ARG_W'($urandom);
        if (it.opcode == qci_pkg::OP_OUT && $urandom_range(1))
          it.arg_one = qci_pkg::ARG_VALUE_OUT;
        if (it.opcode == qci_pkg::OP_RET && $urandom_range(3) != 0)
          it.opcode = qci_pkg::OP_ADD;
        if (it.opcode == qci_pkg::OP_GOTO ||
            it.opcode >= qci_pkg::OP_GT && it.opcode <= qci_pkg::OP_NE) begin
          it.arg_one = qci_pkg::ARG1_W'($urandom_range(4));
          if (it.opcode == qci_pkg::OP_GOTO) it.arg_one = qci_pkg::ARG1_W'($urandom_range(6));
          else it.arg_three = qci_pkg::ARG_W'($urandom_range(6));
        end
        if (it.action == qci_pkg::ACT_LOAD) it.action = 1'b1;
      end
      add_instr(it);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 0;
    hold_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.opcode = '0;
    in_ch.arg_one = '0;
    in_ch.arg_two = '0;
    in_ch.arg_three = '0;
    in_ch.data_word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    foreach (vals[i]) vals[i] = '0;
    foreach (idx_stack[i]) idx_stack[i] = '0;
    depth_used = 0;
    pc = '0;
    stopped = 1'b0;
    main_line = '0;
    prog_len = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length zero halts at once, then each opcode, stack overflow and program length edges
    add_instr(mk(1'b1, qci_pkg::OP_OUT, 1, 0, 0, 0));
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, 8191, 0, 32'h7fffffff));
    wait_drained();
    write_reg(qci_pkg::CFG_START_LINE, 16'd0);
    write_reg(qci_pkg::CFG_PROG_LEN, 16'd4096);
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, 1, 0, 32'h80000000));
    add_instr(mk(1'b1, qci_pkg::OP_IN, 2, 0, 0, -1));
    add_instr(mk(1'b1, qci_pkg::OP_DIV, 3, 1, 2, 0));
    add_instr(mk(1'b1, qci_pkg::OP_MOD, 4, 1, 2, 0));
    add_instr(mk(1'b1, qci_pkg::OP_DIV, 5, 1, 6, 0));
    add_instr(mk(1'b1, qci_pkg::OP_OUT, -1, 3, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_OUT, 8191, 0, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_OUT, -8192, 0, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_ADD, 6, 1, 1, 0));
    add_instr(mk(1'b1, qci_pkg::OP_SUB, 7, 6, 2, 0));
    add_instr(mk(1'b1, qci_pkg::OP_COPY, -2, 7, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_GT, 2, 1, 4096, 0));
    for (int i = 0; i < 5; i++)
      add_instr(mk(1'b1, qci_pkg::OP_W'(int'(qci_pkg::OP_LT) + i), 1, 2, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_GOTO, -5, 0, 0, 0));
    add_instr(mk(1'b1, 5'd31, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      add_instr(mk(1'b1, i[0] ? qci_pkg::OP_PARAM : qci_pkg::OP_CALL, 9, 0, 8191, 0));
    add_instr(mk(1'b1, qci_pkg::OP_RET, -8192, 0, 0, 0));
    add_instr(mk(1'b1, qci_pkg::OP_ADD, 0, 0, 0, 0));
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, 0, 0, 5));
    add_instr(mk(1'b1, qci_pkg::OP_RET, 3, 0, 0, 0));
    wait_drained();
    write_reg(qci_pkg::CFG_START_LINE, 16'd4095);
    write_reg(qci_pkg::CFG_PROG_LEN, 16'd4095);
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, 0, 0, 1));
    add_instr(mk(1'b1, qci_pkg::OP_OUT, 1, 0, 0, 0));
    wait_drained();
    write_reg(qci_pkg::CFG_PROG_LEN, 16'd4096);
    add_instr(mk(qci_pkg::ACT_LOAD, qci_pkg::OP_OUT, 0, 0, 0, 1));
    add_instr(mk(1'b1, qci_pkg::OP_OUT, 1, 0, 0, 0));
    wait_drained();

    // random phases with several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(qci_pkg::CFG_START_LINE, qci_pkg::CFG_DATA_W'($urandom_range(3)));
      write_reg(qci_pkg::CFG_PROG_LEN,
                qci_pkg::CFG_DATA_W'(ph == 5 ? 4096 : $urandom_range(4, 12)));
      no_idle = (ph == 2);
      if (ph == 3) hold_cycles = 400;
      for (int g = 0; g < 10; g++) queue_program($urandom_range(7, 14));
      wait_drained();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/qci_pkg.sv
src/qci_if.sv
src/qci_ram.sv
src/qci_divider.sv
src/qci_datapath.sv
src/qci_controller.sv
src/quad_code_interpreter.sv
verif/tb_quad_code_interpreter.sv
